// File: hw/rtl/triangle_p1_basis_gradient_assert.svh
// assertion macros for the triangle gradient block
`ifndef TRIANGLE_P1_BASIS_GRADIENT_ASSERT_SVH
`define TRIANGLE_P1_BASIS_GRADIENT_ASSERT_SVH

`ifndef SYNTHESIS
`define TPBG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpbg assertion failed");
`define TPBG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpbg assertion failed");
`else
`define TPBG_ASSERT_NOW(lbl, ante, cons)
`define TPBG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/tpbg_pkg.sv
`default_nettype none
package tpbg_pkg;

  localparam int CW  = 32;
  localparam int IXW = 20;
  localparam int TNW = 20;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int INDEX_BITS_DEF  = 20;
  localparam int TRI_CNT_BITS_DEF = 20;

  // edge difference, multiplier operand, product, quotient bits
  localparam int DW  = CW + 1;
  localparam int OPW = 2 * DW + 2;
  localparam int PW  = 2 * OPW;
  localparam int QB  = 34;

  localparam logic [CW-1:0] GRAD_MAX = 32'h7fff_ffff;
  localparam logic [CW-1:0] GRAD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by_coord;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [IXW-1:0]       index_a;
    logic [IXW-1:0]       index_b;
    logic [IXW-1:0]       index_c;
  } in_t;

  typedef struct packed {
    logic [TNW-1:0]       triangle_number;
    logic [IXW-1:0]       vertex_number;
    logic signed [CW-1:0] grad_x;
    logic signed [CW-1:0] grad_y;
    logic signed [CW-1:0] grad_z;
    logic                 saturated;
    logic                 degenerate;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } coord3_t;

endpackage
`default_nettype wire

// File: hw/rtl/tpbg_mul.sv
`default_nettype none
module tpbg_mul
  import tpbg_pkg::*;
#(
  parameter int OP_W = OPW,
  parameter int P_W  = PW
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic signed [OP_W-1:0] a,
  input  wire logic signed [OP_W-1:0] b,
  output logic                        done,
  output logic signed [P_W-1:0]       prod
);

  localparam int CNTW = $clog2(OP_W);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [P_W-1:0]  acc_r;
  logic [P_W-1:0]  mc_r;
  logic [OP_W-1:0] mp_r;
  logic            neg_r;
  logic [OP_W-1:0] a_mag;
  logic [OP_W-1:0] b_mag;

  assign a_mag = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
  assign b_mag = b[OP_W-1] ? OP_W'(-b) : OP_W'(b);

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        mc_r   <= P_W'(a_mag);
        mp_r   <= b_mag;
        neg_r  <= a[OP_W-1] ^ b[OP_W-1];
        cnt_r  <= CNTW'(OP_W - 1);
      end else if (busy_r) begin
        if (mp_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r <= mc_r << 1;
        mp_r <= mp_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule
`default_nettype wire

// File: hw/rtl/tpbg_div.sv
`default_nettype none
module tpbg_div
  import tpbg_pkg::*;
#(
  parameter int NUM_W = PW + 2 * FRAC_BITS_DEF,
  parameter int DEN_W = PW,
  parameter int Q_W   = QB
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quo,
  output logic                  rnd,
  output logic                  ovf
);

  localparam int DSW  = DEN_W + Q_W;
  localparam int MW   = (NUM_W > DSW) ? NUM_W : DSW;
  localparam int CNTW = $clog2(Q_W + 1);

  logic            busy_r;
  logic            done_r;
  logic            ovf_r;
  logic [CNTW-1:0] cnt_r;
  logic [MW-1:0]   rem_r;
  logic [MW-1:0]   dsh_r;
  logic [Q_W-1:0]  q_r;
  logic            ge;

  assign ge = rem_r >= dsh_r;

  // restoring division; the first step only checks for quotient overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= MW'(num);
        dsh_r  <= MW'(den) << Q_W;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= CNTW'(Q_W);
      end else if (busy_r) begin
        if (cnt_r == CNTW'(Q_W)) begin
          ovf_r <= ge;
        end else begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r <= {q_r[Q_W-2:0], ge};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign ovf  = ovf_r;
  assign rnd  = {rem_r, 1'b0} >= {1'b0, MW'(den)};

endmodule
`default_nettype wire

// File: hw/rtl/triangle_p1_basis_gradient.sv
`default_nettype none
`include "triangle_p1_basis_gradient_assert.svh"
// Per-triangle gradients of the three linear hat functions. One triangle is
// taken per item and gives three result items, one per corner in order, the
// third marked last; in_ready is high only while no triangle is in work. All
// arithmetic is exact: a shared bit-serial signed multiplier (OPW = 68
// steps per product) forms the face normal, its squared length and each
// corner's numerator, and a shared restoring divider (35 steps) forms
// each rounded, saturated component. Any output stall holds the triangle in
// work; a degenerate triangle finishes after the first 9 products.
module triangle_p1_basis_gradient
  import tpbg_pkg::*;
#(
  parameter int COORD_FRAC_BITS     = FRAC_BITS_DEF,
  parameter int INDEX_BITS          = INDEX_BITS_DEF,
  parameter int TRIANGLE_COUNT_BITS = TRI_CNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int NUMW = PW + 2 * COORD_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    OP_N0A, OP_N0B, OP_N1A, OP_N1B, OP_N2A, OP_N2B,
    OP_S0, OP_S1, OP_S2,
    OP_G0A, OP_G0B, OP_G1A, OP_G1B, OP_G2A, OP_G2B
  } op_t;

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  state_t state_r, state_nxt;
  op_t    op_r;

  coord3_t              va_r, vb_r, vc_r;
  logic [IXW-1:0]       ia_r, ib_r, ic_r;
  logic [1:0]           corner_r;
  logic [1:0]           dc_r;
  logic                 deg_r;
  logic                 sat_r;
  logic signed [OPW-1:0] nx_r, ny_r, nz_r;
  logic signed [PW-1:0]  nsq_r;
  logic signed [PW-1:0]  gx_r, gy_r, gz_r;
  logic signed [CW-1:0]  rx_r, ry_r, rz_r;
  logic [TRIANGLE_COUNT_BITS-1:0] cnt_r;
  logic                 out_valid_r;
  logic                 mul_go_r;
  logic                 div_go_r;

  coord3_t              cur, nxt, prv;
  logic [IXW-1:0]       vsel;
  logic [INDEX_BITS-1:0] vsel_m;
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [OPW-1:0] ma, mb;
  logic                 mul_done;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  nsq_sum;
  logic signed [PW-1:0]  gsel;
  logic                 gneg;
  logic [PW-1:0]        gmag;
  logic [NUMW-1:0]      num;
  logic                 div_done;
  logic [QB-1:0]        quo;
  logic                 rnd;
  logic                 ovf;
  logic [QB:0]          qmag;
  logic [QB:0]          qlim;
  logic                 qsat;
  logic signed [CW-1:0] qval;

  always_comb begin
    case (corner_r)
      CORNER_A: begin
        cur = va_r; nxt = vb_r; prv = vc_r; vsel = ia_r;
      end
      CORNER_B: begin
        cur = vb_r; nxt = vc_r; prv = va_r; vsel = ib_r;
      end
      default: begin
        cur = vc_r; nxt = va_r; prv = vb_r; vsel = ic_r;
      end
    endcase
  end

  assign ux = DW'(cur.x) - DW'(prv.x);
  assign uy = DW'(cur.y) - DW'(prv.y);
  assign uz = DW'(cur.z) - DW'(prv.z);
  assign vx = DW'(nxt.x) - DW'(prv.x);
  assign vy = DW'(nxt.y) - DW'(prv.y);
  assign vz = DW'(nxt.z) - DW'(prv.z);

  // n = u x v, |n|^2, g = v x n
  always_comb begin
    case (op_r)
      OP_N0A:  begin ma = OPW'(uy); mb = OPW'(vz); end
      OP_N0B:  begin ma = OPW'(uz); mb = OPW'(vy); end
      OP_N1A:  begin ma = OPW'(uz); mb = OPW'(vx); end
      OP_N1B:  begin ma = OPW'(ux); mb = OPW'(vz); end
      OP_N2A:  begin ma = OPW'(ux); mb = OPW'(vy); end
      OP_N2B:  begin ma = OPW'(uy); mb = OPW'(vx); end
      OP_S0:   begin ma = nx_r;     mb = nx_r;     end
      OP_S1:   begin ma = ny_r;     mb = ny_r;     end
      OP_S2:   begin ma = nz_r;     mb = nz_r;     end
      OP_G0A:  begin ma = OPW'(vy); mb = nz_r;     end
      OP_G0B:  begin ma = OPW'(vz); mb = ny_r;     end
      OP_G1A:  begin ma = OPW'(vz); mb = nx_r;     end
      OP_G1B:  begin ma = OPW'(vx); mb = nz_r;     end
      OP_G2A:  begin ma = OPW'(vx); mb = ny_r;     end
      OP_G2B:  begin ma = OPW'(vy); mb = nx_r;     end
      default: begin ma = '0;       mb = '0;       end
    endcase
  end

  tpbg_mul #(
    .OP_W (OPW),
    .P_W  (PW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (prod)
  );

  assign nsq_sum = nsq_r + prod;

  always_comb begin
    case (dc_r)
      2'd0:    gsel = gx_r;
      2'd1:    gsel = gy_r;
      default: gsel = gz_r;
    endcase
  end

  assign gneg = gsel[PW-1];
  assign gmag = gneg ? PW'(-gsel) : PW'(gsel);
  assign num  = NUMW'(gmag) << (2 * COORD_FRAC_BITS);

  tpbg_div #(
    .NUM_W (NUMW),
    .DEN_W (PW),
    .Q_W   (QB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (num),
    .den   (nsq_r),
    .done  (div_done),
    .quo   (quo),
    .rnd   (rnd),
    .ovf   (ovf)
  );

  assign qmag = {1'b0, quo} + (QB + 1)'(rnd);
  assign qlim = gneg ? (QB + 1)'(GRAD_MIN) : (QB + 1)'(GRAD_MAX);
  assign qsat = ovf || (qmag > qlim);
  assign qval = qsat ? (gneg ? GRAD_MIN : GRAD_MAX)
                     : (gneg ? -$signed(qmag[CW-1:0]) : $signed(qmag[CW-1:0]));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL: begin
        if (mul_done) begin
          if (op_r == OP_S2 && nsq_sum == '0) begin
            state_nxt = S_OUT;
          end else if (op_r == OP_G2B) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: if (div_done && dc_r == 2'd2) state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          if (corner_r == CORNER_C) begin
            state_nxt = S_IDLE;
          end else if (!deg_r) begin
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      deg_r       <= 1'b0;
      sat_r       <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            va_r     <= '{x: in_data.ax, y: in_data.ay, z: in_data.az};
            vb_r     <= '{x: in_data.bx, y: in_data.by_coord, z: in_data.bz};
            vc_r     <= '{x: in_data.cx, y: in_data.cy, z: in_data.cz};
            ia_r     <= in_data.index_a;
            ib_r     <= in_data.index_b;
            ic_r     <= in_data.index_c;
            corner_r <= CORNER_A;
            op_r     <= OP_N0A;
            deg_r    <= 1'b0;
            sat_r    <= 1'b0;
            mul_go_r <= 1'b1;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            case (op_r)
              OP_N0A:  nx_r  <= OPW'(prod);
              OP_N0B:  nx_r  <= nx_r - OPW'(prod);
              OP_N1A:  ny_r  <= OPW'(prod);
              OP_N1B:  ny_r  <= ny_r - OPW'(prod);
              OP_N2A:  nz_r  <= OPW'(prod);
              OP_N2B:  nz_r  <= nz_r - OPW'(prod);
              OP_S0:   nsq_r <= prod;
              OP_S1:   nsq_r <= nsq_sum;
              OP_S2:   nsq_r <= nsq_sum;
              OP_G0A:  gx_r  <= prod;
              OP_G0B:  gx_r  <= gx_r - prod;
              OP_G1A:  gy_r  <= prod;
              OP_G1B:  gy_r  <= gy_r - prod;
              OP_G2A:  gz_r  <= prod;
              OP_G2B:  gz_r  <= gz_r - prod;
              default: nsq_r <= nsq_r;
            endcase
            if (op_r == OP_S2 && nsq_sum == '0) begin
              deg_r       <= 1'b1;
              out_valid_r <= 1'b1;
            end else if (op_r == OP_G2B) begin
              dc_r     <= 2'd0;
              div_go_r <= 1'b1;
            end else begin
              op_r     <= op_t'(op_r + 1'b1);
              mul_go_r <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (dc_r)
              2'd0:    rx_r <= qval;
              2'd1:    ry_r <= qval;
              default: rz_r <= qval;
            endcase
            sat_r <= sat_r | qsat;
            if (dc_r == 2'd2) begin
              out_valid_r <= 1'b1;
            end else begin
              dc_r     <= dc_r + 1'b1;
              div_go_r <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (corner_r == CORNER_C) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              corner_r <= corner_r + 1'b1;
              sat_r    <= 1'b0;
              if (deg_r) begin
                out_valid_r <= 1'b1;
              end else begin
                op_r     <= OP_G0A;
                mul_go_r <= 1'b1;
              end
            end
          end
        end
        default: out_valid_r <= 1'b0;
      endcase
    end
  end

  assign vsel_m = INDEX_BITS'(vsel);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    out_data.triangle_number = TNW'(cnt_r);
    out_data.vertex_number   = IXW'(vsel_m);
    out_data.grad_x          = deg_r ? '0 : rx_r;
    out_data.grad_y          = deg_r ? '0 : ry_r;
    out_data.grad_z          = deg_r ? '0 : rz_r;
    out_data.saturated       = sat_r & ~deg_r;
    out_data.degenerate      = deg_r;
    out_data.last            = (corner_r == CORNER_C);
  end

  `TPBG_ASSERT_NOW(a_ready_no_result, in_ready, !out_valid)
  `TPBG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `TPBG_ASSERT_NEXT(a_idle_after_last, out_valid && out_ready && out_data.last, in_ready)
  `TPBG_ASSERT_NOW(a_degenerate_zero, out_valid && out_data.degenerate,
                   out_data.grad_x == '0 && out_data.grad_y == '0 && !out_data.saturated)

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import tpbg_pkg::*;

  typedef logic signed [191:0] swide_t;
  typedef logic [191:0] uwide_t;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_CYCLES = 6000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t grad_q[$];
  logic [TNW-1:0] tri_count;
  int mismatches;
  int results_seen;
  int items_sent;
  int degen_seen;
  int sat_seen;
  int idle_cnt;
  bit quiet;
  bit hold_req;

  triangle_p1_basis_gradient dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void predict_gradients(in_t t);
    longint p[3][3];
    logic [IXW-1:0] idx[3];
    swide_t u[3], v[3], n[3], g[3], n2;
    uwide_t mag, q, r, lim;
    logic [CW-1:0] comp[3];
    logic neg, sat;
    int nx, pv;
    out_t o;
    p[0][0] = t.ax; p[0][1] = t.ay;       p[0][2] = t.az;
    p[1][0] = t.bx; p[1][1] = t.by_coord; p[1][2] = t.bz;
    p[2][0] = t.cx; p[2][1] = t.cy;       p[2][2] = t.cz;
    idx[0] = t.index_a; idx[1] = t.index_b; idx[2] = t.index_c;
    for (int k = 0; k < 3; k++) begin
      nx = (k + 1) % 3;
      pv = (k + 2) % 3;
      for (int c = 0; c < 3; c++) begin
        u[c] = p[k][c] - p[pv][c];
        v[c] = p[nx][c] - p[pv][c];
      end
      n[0] = u[1] * v[2] - u[2] * v[1];
      n[1] = u[2] * v[0] - u[0] * v[2];
      n[2] = u[0] * v[1] - u[1] * v[0];
      g[0] = v[1] * n[2] - v[2] * n[1];
      g[1] = v[2] * n[0] - v[0] * n[2];
      g[2] = v[0] * n[1] - v[1] * n[0];
      n2 = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
      sat = 1'b0;
      for (int c = 0; c < 3; c++) begin
        if (n2 == 0) begin
          comp[c] = '0;
        end else begin
          neg = g[c] < 0;
          mag = neg ? uwide_t'(-g[c]) : uwide_t'(g[c]);
          mag = mag << (2 * FRAC_BITS_DEF);
          q = mag / uwide_t'(n2);
          r = mag % uwide_t'(n2);
          if ((r << 1) >= uwide_t'(n2)) q = q + 1;
          lim = neg ? uwide_t'(64'h8000_0000) : uwide_t'(64'h7fff_ffff);
          if (q > lim) begin
            sat = 1'b1;
            comp[c] = neg ? GRAD_MIN : GRAD_MAX;
          end else begin
            comp[c] = neg ? -q[CW-1:0] : q[CW-1:0];
          end
        end
      end
      o.triangle_number = tri_count;
      o.vertex_number = idx[k];
      o.grad_x = comp[0];
      o.grad_y = comp[1];
      o.grad_z = comp[2];
      o.saturated = sat;
      o.degenerate = (n2 == 0);
      o.last = (k == 2);
      grad_q.push_back(o);
    end
    tri_count = tri_count + 1'b1;
  endfunction

  task automatic send_triangle(in_t t);
    if (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    predict_gradients(t);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (grad_q.size() != 0) @(posedge clk);
  endtask

  function automatic in_t make_tri(longint a[3], longint b[3], longint c[3],
                                   logic [IXW-1:0] ia, logic [IXW-1:0] ib,
                                   logic [IXW-1:0] ic);
    in_t t;
    t.ax = CW'(a[0]); t.ay = CW'(a[1]); t.az = CW'(a[2]);
    t.bx = CW'(b[0]); t.by_coord = CW'(b[1]); t.bz = CW'(b[2]);
    t.cx = CW'(c[0]); t.cy = CW'(c[1]); t.cz = CW'(c[2]);
    t.index_a = ia; t.index_b = ib; t.index_c = ic;
    return t;
  endfunction

  function automatic in_t random_tri();
    in_t t;
    longint a[3], b[3], c[3];
    longint spread;
    longint hi_lim, lo_lim;
    int mode;
    hi_lim = (longint'(1) << 31) - 1;
    lo_lim = -(longint'(1) << 31);
    mode = $urandom_range(0, 9);
    spread = (mode == 7) ? 4 : (mode < 3 ? 0 : longint'(1) << $urandom_range(4, 24));
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed($urandom()) >>> $urandom_range(0, 8);
      if (spread == 0) begin
        b[i] = $signed($urandom());
        c[i] = $signed($urandom());
      end else begin
        b[i] = a[i] + longint'($urandom_range(0, 2 * spread)) - spread;
        c[i] = a[i] + longint'($urandom_range(0, 2 * spread)) - spread;
      end
    end
    // collinear or coincident corners
    if (mode == 8) for (int i = 0; i < 3; i++) c[i] = a[i] + 2 * (b[i] - a[i]);
    if (mode == 9) for (int i = 0; i < 3; i++) c[i] = b[i];
    for (int i = 0; i < 3; i++) begin
      if (b[i] > hi_lim || b[i] < lo_lim) b[i] = a[i];
      if (c[i] > hi_lim || c[i] < lo_lim) c[i] = a[i];
    end
    t = make_tri(a, b, c, IXW'($urandom()), IXW'($urandom()), IXW'($urandom()));
    return t;
  endfunction

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 32);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (grad_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", out_data);
      end else begin
        if (out_data.triangle_number !== grad_q[0].triangle_number ||
            out_data.vertex_number !== grad_q[0].vertex_number ||
            out_data.grad_x !== grad_q[0].grad_x ||
            out_data.grad_y !== grad_q[0].grad_y ||
            out_data.grad_z !== grad_q[0].grad_z ||
            out_data.saturated !== grad_q[0].saturated ||
            out_data.degenerate !== grad_q[0].degenerate ||
            out_data.last !== grad_q[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", grad_q[0], out_data);
        end
        if (grad_q[0].degenerate) degen_seen++;
        if (grad_q[0].saturated) sat_seen++;
        void'(grad_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", grad_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic test_directed();
    longint a[3], b[3], c[3];
    a = '{0, 0, 0}; b = '{65536, 0, 0}; c = '{0, 65536, 0};
    send_triangle(make_tri(a, b, c, 0, 1, 2));
    a = '{65536, 131072, -65536}; b = '{-196608, 65536, 262144}; c = '{0, -65536, 65536};
    send_triangle(make_tri(a, b, c, 20'hfffff, 20'h00001, 20'h80000));
    a = '{-2147483648, -2147483648, -2147483648};
    b = '{2147483647, -2147483648, 2147483647};
    c = '{-2147483648, 2147483647, 2147483647};
    send_triangle(make_tri(a, b, c, 20'hfffff, 20'hfffff, 20'hfffff));
    a = '{2147483647, 2147483647, 0}; b = '{-2147483648, 0, 0}; c = '{0, -2147483648, 0};
    send_triangle(make_tri(a, b, c, 0, 0, 0));
    // coincident corners
    a = '{1000, 2000, 3000}; b = a; c = '{5000, -7000, 9};
    send_triangle(make_tri(a, b, c, 7, 8, 9));
    a = '{-5, -5, -5}; b = a; c = a;
    send_triangle(make_tri(a, b, c, 3, 3, 3));
    // collinear corners
    a = '{0, 0, 0}; b = '{65536, 65536, 65536}; c = '{-131072, -131072, -131072};
    send_triangle(make_tri(a, b, c, 11, 12, 13));
    // tiny triangles; the first two saturate
    a = '{0, 0, 0}; b = '{1, 0, 0}; c = '{0, 1, 0};
    send_triangle(make_tri(a, b, c, 100, 101, 102));
    a = '{-40, 70, 3}; b = '{-39, 70, 3}; c = '{-40, 70, 4};
    send_triangle(make_tri(a, b, c, 1, 2, 3));
    a = '{0, 0, 0}; b = '{256, 0, 0}; c = '{128, 3, 1};
    send_triangle(make_tri(a, b, c, 4, 5, 6));
    // long thin triangle
    a = '{-2147483648, 0, 0}; b = '{2147483647, 0, 0}; c = '{0, 1, 0};
    send_triangle(make_tri(a, b, c, 9, 10, 11));
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    quiet = 1'b1;
    for (int i = 0; i < 4; i++) send_triangle(random_tri());
    in_valid <= 1'b0;
    wait_drained();
    quiet = 1'b0;
    for (int i = 0; i < 3; i++) send_triangle(random_tri());
    in_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3) && (i < count / 3 + 60);
      send_triangle(random_tri());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    tri_count = '0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    degen_seen = 0;
    sat_seen = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(340);
    wait_drained();
    repeat (3000) @(posedge clk);
    $display("sent %0d triangles, checked %0d corner gradients", items_sent, results_seen);
    $display("%0d degenerate and %0d saturated corners seen", degen_seen, sat_seen);
    if (mismatches == 0 && grad_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, grad_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
